[rtl/core/csvt_pkg.sv]
// Package for the CSV byte tokenizer: token codes, character constants,
// result word and parser state types. No dependencies.
package csvt_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_ERROR = 2'd3
  } tok_kind_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] MARK_B0  = 8'hEF;
  localparam logic [7:0] MARK_B1  = 8'hBB;
  localparam logic [7:0] MARK_B2  = 8'hBF;

  // most result words one input byte can cause
  localparam int RES_MAX = 4;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic in_quoted;
    logic quote_pending;
    logic drop_next_lf;
    logic row_begun;
    logic field_has_bytes;
  } parse_st_t;

endpackage

[rtl/core/csvt_if.sv]
// Valid/ready channel interfaces of the CSV byte tokenizer.
// Depends on nothing; payload widths follow the token format in csvt_pkg.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, text_byte, final_byte, input ready);
  modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] content_byte;
  logic       run_last;

  modport source (output valid, token_kind, content_byte, run_last, input ready);
  modport sink   (input valid, token_kind, content_byte, run_last, output ready);
endinterface

[rtl/core/csv_byte_tokenizer_core.sv]
// CSV byte tokenizer. A byte's result words are registered into the result buffer when it is taken.
// Throughput: one byte per cycle while each byte yields at most one word and out ready is high; a byte
// yields up to 4 words, drained one per cycle while out ready is high, from a DEPTH-entry result buffer.
// in ready is high whenever at least 4 buffer slots are free.
// Reset: synchronous, active low; clears parser state and buffer pointers.
// Uses csvt_pkg and the csvt_in_if / csvt_out_if channel interfaces.
module csv_byte_tokenizer_core
  import csvt_pkg::*;
#(
  parameter int DEPTH = 8  // result buffer entries, power of two, at least 4
) (
  input  logic              clk,
  input  logic              rst_n,
  csvt_in_if.sink           in_word,
  csvt_out_if.source        out_word
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  // start-of-text byte order mark tracking
  typedef enum logic [1:0] {
    MK_START,  // nothing seen yet
    MK_EF,     // EF held
    MK_EFBB,   // EF BB held
    MK_PAST    // past the start of text
  } mark_t;

  typedef struct packed {
    parse_st_t st;
    logic      emit;
    tok_t      tok;
  } take_t;

  // One byte through the field/row parser; emits at most one word.
  function automatic take_t take_byte(parse_st_t s, logic [7:0] b);
    take_t r;
    logic  go;
    r      = '0;
    r.st   = s;
    r.emit = 1'b0;
    r.tok  = '{kind: KIND_BYTE, data: 8'h00, last: 1'b0};
    go     = 1'b1;
    if (s.drop_next_lf) begin
      r.st.drop_next_lf = 1'b0;
      if (b == CH_LF) go = 1'b0;
    end
    if (go && s.in_quoted) begin
      if (s.quote_pending) begin
        r.st.quote_pending = 1'b0;
        if (b == CH_QUOTE) begin
          // doubled quote gives one quote
          r.emit = 1'b1;
          r.tok.data = CH_QUOTE;
          r.st.field_has_bytes = 1'b1;
          go = 1'b0;
        end else begin
          r.st.in_quoted = 1'b0;  // closing quote; b handled below
        end
      end else begin
        go = 1'b0;
        if (b == CH_QUOTE) begin
          r.st.quote_pending = 1'b1;
        end else if (b == CH_CR) begin
          r.emit = 1'b1;
          r.tok.data = CH_LF;
          r.st.field_has_bytes = 1'b1;
          r.st.drop_next_lf = 1'b1;
        end else begin
          r.emit = 1'b1;
          r.tok.data = b;
          r.st.field_has_bytes = 1'b1;
        end
      end
    end
    if (go) begin
      if (b == CH_QUOTE && !r.st.field_has_bytes) begin
        r.st.in_quoted = 1'b1;
        r.st.row_begun = 1'b1;
      end else if (b == CH_COMMA) begin
        r.emit = 1'b1;
        r.tok.kind = KIND_FIELD;
        r.st.field_has_bytes = 1'b0;
        r.st.row_begun = 1'b1;
      end else if (b == CH_CR || b == CH_LF) begin
        if (b == CH_CR) r.st.drop_next_lf = 1'b1;
        // blank lines give nothing
        if (r.st.row_begun || r.st.field_has_bytes) begin
          r.emit = 1'b1;
          r.tok.kind = KIND_ROW;
          r.st.row_begun = 1'b0;
          r.st.field_has_bytes = 1'b0;
        end
      end else begin
        r.emit = 1'b1;
        r.tok.data = b;
        r.st.field_has_bytes = 1'b1;
        r.st.row_begun = 1'b1;
      end
    end
    return r;
  endfunction

  parse_st_t           st_r, st_nxt;
  mark_t               mark_r, mark_nxt;
  tok_t                buf_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                accept, pop;
  logic [7:0]          b;
  logic                fin;

  // up to three parser slots per byte (held mark bytes replayed first)
  logic [7:0]          slot_byte [3];
  logic [2:0]          slot_en;
  take_t               tk [3];
  parse_st_t           st_chain [4];
  parse_st_t           st_fin;

  tok_t                res [RES_MAX];
  logic [RES_MAX-1:0]  res_v;
  logic [2:0]          res_off [RES_MAX];
  logic [2:0]          n_wr;

  assign b      = in_word.text_byte;
  assign fin    = in_word.final_byte;
  assign in_word.ready = (cnt_r <= CNT_W'(DEPTH - RES_MAX));
  assign accept = in_word.valid && in_word.ready;

  assign out_word.valid        = (cnt_r != '0);
  assign out_word.token_kind   = buf_r[rd_ptr_r].kind;
  assign out_word.content_byte = buf_r[rd_ptr_r].data;
  assign out_word.run_last     = buf_r[rd_ptr_r].last;
  assign pop = out_word.valid && out_word.ready;

  // mark stripping: decide which bytes reach the parser
  always_comb begin
    slot_byte[0] = b;
    slot_byte[1] = b;
    slot_byte[2] = b;
    slot_en      = 3'b000;
    mark_nxt     = MK_PAST;
    case (mark_r)
      MK_START: begin
        if (b == MARK_B0 && !fin) mark_nxt = MK_EF;
        else slot_en = 3'b001;
      end
      MK_EF: begin
        if (b == MARK_B1 && !fin) begin
          mark_nxt = MK_EFBB;
        end else begin
          slot_byte[0] = MARK_B0;  // replay held EF
          slot_en = 3'b011;
        end
      end
      MK_EFBB: begin
        if (b != MARK_B2) begin
          slot_byte[0] = MARK_B0;
          slot_byte[1] = MARK_B1;
          slot_en = 3'b111;
        end
      end
      MK_PAST: slot_en = 3'b001;
      default: slot_en = 3'b001;
    endcase
    if (fin) mark_nxt = MK_START;
  end

  // parser chain and end-of-text handling
  always_comb begin
    st_chain[0] = st_r;
    for (int i = 0; i < 3; i++) begin
      tk[i] = take_byte(st_chain[i], slot_byte[i]);
      st_chain[i+1] = slot_en[i] ? tk[i].st : st_chain[i];
      res[i]   = tk[i].tok;
      res_v[i] = slot_en[i] && tk[i].emit;
    end
    st_fin = st_chain[3];
    res[3]   = '{kind: KIND_ROW, data: 8'h00, last: 1'b0};
    res_v[3] = 1'b0;
    st_nxt   = st_fin;
    if (fin) begin
      // a pending quote at the end is a closing quote
      if (st_fin.quote_pending) st_fin.in_quoted = 1'b0;
      if (st_fin.in_quoted) begin
        res[3].kind = KIND_ERROR;
        res_v[3] = 1'b1;
      end else if (st_fin.row_begun || st_fin.field_has_bytes) begin
        res_v[3] = 1'b1;
      end
      st_nxt = '0;
    end
    // flag the last word of this byte and pack the words together
    n_wr = 3'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i].last = res_v[i] && ((res_v >> (i + 1)) == '0);
      res_off[i]  = n_wr;
      n_wr = n_wr + {2'b00, res_v[i]};
    end
    cnt_nxt = cnt_r + (accept ? CNT_W'(n_wr) : '0) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      mark_r   <= MK_START;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        st_r     <= st_nxt;
        mark_r   <= mark_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_wr);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    // buffer payload, no reset
    if (accept) begin
      for (int i = 0; i < RES_MAX; i++) begin
        if (res_v[i]) buf_r[wr_ptr_r + PTR_W'(res_off[i])] <= res[i];
      end
    end
  end

endmodule

[rtl/core/csvt_checker.sv]
// Port-level checks for csv_byte_tokenizer_core, bound to every instance.
// Uses csvt_pkg token codes.
module csvt_checker
  import csvt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_last))
    else $error("result word changed while stalled");

  // markers carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_byte == 8'h00)
    else $error("marker word with nonzero byte");

  // error is always the closing word of its byte
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last)
    else $error("error word not flagged last");

  // empty buffer never blocks input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with nothing pending");

  // words only appear after a byte was taken
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without an input byte");

endmodule

bind csv_byte_tokenizer_core csvt_checker u_csvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .out_kind  (out_word.token_kind),
  .out_byte  (out_word.content_byte),
  .out_last  (out_word.run_last)
);

[dv/tb_csv_byte_tokenizer_core.sv]
// Testbench for csv_byte_tokenizer_core: directed table plus random CSV texts.
// Each token word is checked against a local tokenizer model, or typed words for some directed rows.
// Depends on csvt_pkg, csvt_in_if / csvt_out_if and the core RTL.
`timescale 1ns / 100ps

module tb_csv_byte_tokenizer_core;
  import csvt_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int          RESET_CYCLES    = 12;
  localparam int          ITEMS_PER_PHASE = 70;       // 4 phases + directed, ~320 bytes
  localparam int          LONG_HOLD       = 200;      // sink hold-off, cycles
  localparam int unsigned CYCLE_LIMIT     = 200_000;  // watchdog

  // sender idle / sink stall, percent per cycle, one entry per phase
  localparam int IDLE_PCT  [4] = '{0, 53, 0, 36};
  localparam int STALL_PCT [4] = '{0, 0, 53, 36};

  // bytes that steer the parser, used to salt noise texts
  localparam logic [7:0] SPECIALS [7] = '{CH_QUOTE, CH_COMMA, CH_CR, CH_LF,
                                          MARK_B0, MARK_B1, MARK_B2};

  // Directed rows. n_typed > 0: the next n_typed words of TYPED_TOKS are the
  // expectation; n_typed == 0: the local model decides.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic [2:0] n_typed;
  } dir_row_t;

  localparam dir_row_t DIRECTED [26] = '{
    '{8'h00,    1'b1, 3'd2},  // lowest byte as a whole text
    '{MARK_B0,  1'b1, 3'd2},  // mark byte carrying final: plain text
    '{CH_QUOTE, 1'b1, 3'd1},  // lone open quote: unterminated
    '{MARK_B0,  1'b0, 3'd0},  // full mark, stripped
    '{MARK_B1,  1'b0, 3'd0},
    '{MARK_B2,  1'b0, 3'd0},
    '{CH_QUOTE, 1'b0, 3'd0},  // open quoted field
    '{CH_COMMA, 1'b0, 3'd0},  // comma held inside quotes
    '{CH_QUOTE, 1'b0, 3'd0},  // doubled quote -> one quote
    '{CH_QUOTE, 1'b0, 3'd0},
    '{CH_CR,    1'b0, 3'd0},  // CRLF inside quotes -> LF
    '{CH_LF,    1'b0, 3'd0},
    '{CH_QUOTE, 1'b0, 3'd0},  // closing quote ...
    '{"x",      1'b0, 3'd0},  // ... then bytes after it, same field
    '{CH_COMMA, 1'b0, 3'd0},  // field end
    '{"y",      1'b0, 3'd0},
    '{CH_QUOTE, 1'b0, 3'd0},  // quote mid unquoted field: content
    '{CH_CR,    1'b0, 3'd0},  // CRLF row end outside quotes
    '{CH_LF,    1'b0, 3'd0},
    '{CH_LF,    1'b0, 3'd0},  // blank line: nothing
    '{CH_QUOTE, 1'b0, 3'd0},
    '{8'hFF,    1'b0, 3'd0},  // highest byte, quoted
    '{CH_QUOTE, 1'b1, 3'd0},  // closing quote as final byte
    '{MARK_B0,  1'b0, 3'd0},  // broken mark: EF BB replayed
    '{MARK_B1,  1'b0, 3'd0},
    '{CH_QUOTE, 1'b1, 3'd4}   // four words from one byte
  };

  localparam tok_t TYPED_TOKS [9] = '{
    '{KIND_BYTE,  8'h00,    1'b0}, '{KIND_ROW, 8'h00, 1'b1},
    '{KIND_BYTE,  MARK_B0,  1'b0}, '{KIND_ROW, 8'h00, 1'b1},
    '{KIND_ERROR, 8'h00,    1'b1},
    '{KIND_BYTE,  MARK_B0,  1'b0}, '{KIND_BYTE, MARK_B1, 1'b0},
    '{KIND_BYTE,  CH_QUOTE, 1'b0}, '{KIND_ROW, 8'h00, 1'b1}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  csvt_in_if  text_ch ();
  csvt_out_if tok_ch ();

  csv_byte_tokenizer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (text_ch),
    .out_word (tok_ch)
  );

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {BOM_START, BOM_EF, BOM_EFBB, BOM_PAST} bom_phase_t;

  parse_st_t  scan_st   = '0;
  bom_phase_t bom_phase = BOM_START;
  tok_t       step_toks[$];    // words caused by the byte being modeled
  tok_t       due_tokens[$];   // words still owed by the DUT, oldest first

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_asks = 0;           // bumped by the stimulus to request a long hold
  int fail_count = 0;
  logic [7:0] text_buf[$];     // one CSV text under construction

  // append one byte to the text under construction
  function automatic void add_byte(input logic [7:0] v);
    text_buf.insert(text_buf.size(), v);
  endfunction

  // append one word to the expected stream
  function automatic void book(input tok_t t);
    due_tokens.insert(due_tokens.size(), t);
  endfunction

  function automatic void emit(input tok_kind_t kind, input logic [7:0] data);
    tok_t t;
    // a byte never causes more than RES_MAX words
    if (step_toks.size() < RES_MAX) begin
      t.kind = kind;
      t.data = (kind == KIND_BYTE) ? data : 8'h00;
      t.last = 1'b0;
      step_toks.insert(step_toks.size(), t);
    end
  endfunction

  // One byte of text once the leading mark has been resolved.
  function automatic void scan_char(input logic [7:0] b);
    if (scan_st.drop_next_lf) begin
      scan_st.drop_next_lf = 1'b0;
      if (b == CH_LF) return;
    end
    if (scan_st.in_quoted) begin
      if (scan_st.quote_pending) begin
        scan_st.quote_pending = 1'b0;
        if (b == CH_QUOTE) begin
          emit(KIND_BYTE, CH_QUOTE);
          scan_st.field_has_bytes = 1'b1;
          return;
        end
        // quote closed; this byte is handled as unquoted text below
        scan_st.in_quoted = 1'b0;
      end else begin
        if (b == CH_QUOTE) begin
          scan_st.quote_pending = 1'b1;
        end else if (b == CH_CR) begin
          emit(KIND_BYTE, CH_LF);
          scan_st.field_has_bytes = 1'b1;
          scan_st.drop_next_lf    = 1'b1;
        end else begin
          emit(KIND_BYTE, b);
          scan_st.field_has_bytes = 1'b1;
        end
        return;
      end
    end
    if (b == CH_QUOTE && !scan_st.field_has_bytes) begin
      scan_st.in_quoted = 1'b1;
      scan_st.row_begun = 1'b1;
    end else if (b == CH_COMMA) begin
      emit(KIND_FIELD, 8'h00);
      scan_st.field_has_bytes = 1'b0;
      scan_st.row_begun       = 1'b1;
    end else if (b == CH_CR || b == CH_LF) begin
      if (b == CH_CR) scan_st.drop_next_lf = 1'b1;
      // blank lines give no row end
      if (scan_st.row_begun || scan_st.field_has_bytes) begin
        emit(KIND_ROW, 8'h00);
        scan_st.row_begun       = 1'b0;
        scan_st.field_has_bytes = 1'b0;
      end
    end else begin
      emit(KIND_BYTE, b);
      scan_st.field_has_bytes = 1'b1;
      scan_st.row_begun       = 1'b1;
    end
  endfunction

  // Full step for one accepted input word: leading mark, text, end of text.
  function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
    tok_t tail;
    step_toks.delete();
    case (bom_phase)
      BOM_START: begin
        if (b == MARK_B0 && !fin) begin
          bom_phase = BOM_EF;
        end else begin
          bom_phase = BOM_PAST;
          scan_char(b);
        end
      end
      BOM_EF: begin
        if (b == MARK_B1 && !fin) begin
          bom_phase = BOM_EFBB;
        end else begin
          bom_phase = BOM_PAST;
          scan_char(MARK_B0);
          scan_char(b);
        end
      end
      BOM_EFBB: begin
        bom_phase = BOM_PAST;
        // a broken mark replays the held bytes as text
        if (b != MARK_B2) begin
          scan_char(MARK_B0);
          scan_char(MARK_B1);
          scan_char(b);
        end
      end
      default: scan_char(b);
    endcase
    if (fin) begin
      // a pending quote at the end is a closing quote
      if (scan_st.quote_pending) begin
        scan_st.quote_pending = 1'b0;
        scan_st.in_quoted     = 1'b0;
      end
      if (scan_st.in_quoted) emit(KIND_ERROR, 8'h00);
      else if (scan_st.row_begun || scan_st.field_has_bytes) emit(KIND_ROW, 8'h00);
      scan_st   = '0;
      bom_phase = BOM_START;
    end
    if (step_toks.size() > 0) begin
      tail      = step_toks[step_toks.size() - 1];
      tail.last = 1'b1;
      step_toks[step_toks.size() - 1] = tail;
    end
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == CH_QUOTE || v == CH_COMMA || v == CH_CR || v == CH_LF) v = "a";
    return v;
  endfunction

  function automatic void add_row_end();
    case ($urandom_range(2))
      0:       add_byte(CH_CR);
      1:       add_byte(CH_LF);
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one word, waits for the handshake, then books the expected tokens:
  // the typed ones when typed_n > 0, else the model's.
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input int typed_at, input int typed_n);
    while ($urandom_range(99) < idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.text_byte  <= b;
    text_ch.final_byte <= fin;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    tokenize_byte(b, fin);
    if (typed_n == 0) begin
      foreach (step_toks[i]) book(step_toks[i]);
    end else begin
      for (int i = 0; i < typed_n; i++) book(TYPED_TOKS[typed_at + i]);
    end
  endtask

  // Sender goes quiet until every booked token word has arrived.
  task automatic settle();
    text_ch.valid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : token_sink
    int hold_served;
    hold_served = 0;
    tok_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        // hold off long enough for the result buffer to fill and stall input
        tok_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      tok_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted token word against the oldest booked one
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string field, input int unsigned want_v,
                                        input int unsigned got_v);
    fail_count++;
    $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
  endfunction

  always @(posedge clk) begin : token_check
    tok_t want;
    if (rst_n && tok_ch.valid && tok_ch.ready) begin
      if (due_tokens.size() == 0) begin
        fail_count++;
        $error("token word with none expected: token_kind %0d content_byte %0h run_last %0b",
               tok_ch.token_kind, tok_ch.content_byte, tok_ch.run_last);
      end else begin
        want = due_tokens.pop_front();
        if (tok_ch.token_kind != want.kind)
          flag_mismatch("token_kind", want.kind, tok_ch.token_kind);
        if (tok_ch.content_byte != want.data)
          flag_mismatch("content_byte", want.data, tok_ch.content_byte);
        if (tok_ch.run_last != want.last)
          flag_mismatch("run_last", want.last, tok_ch.run_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int  tix;
    int  sent;
    int  style;
    int  rows;
    int  fields;
    int  len;
    bit  hold_taken;

    rst_n              = 1'b0;
    text_ch.valid      = 1'b0;
    text_ch.text_byte  = 8'h00;
    text_ch.final_byte = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side
    tix = 0;
    for (int r = 0; r < $size(DIRECTED); r++) begin
      send_byte(DIRECTED[r].b, DIRECTED[r].fin, tix, int'(DIRECTED[r].n_typed));
      tix += int'(DIRECTED[r].n_typed);
    end
    settle();

    // Random texts, one idling profile per phase
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct   = IDLE_PCT[ph];
      stall_pct  = STALL_PCT[ph];
      hold_taken = 1'b0;
      sent       = 0;
      while (sent < ITEMS_PER_PHASE) begin
        text_buf.delete();
        style = $urandom_range(19);
        if (style < 3) begin
          // noise: random bytes salted with the steering characters
          len = $urandom_range(12, 1);
          repeat (len)
            add_byte($urandom_range(1) ? 8'($urandom) : SPECIALS[$urandom_range(6)]);
        end else if (style == 3) begin
          // text that is only the mark
          add_byte(MARK_B0);
          add_byte(MARK_B1);
          add_byte(MARK_B2);
        end else begin
          // well-formed rows with random content; leading mark full, cut or absent
          case ($urandom_range(5))
            0: begin
              add_byte(MARK_B0);
              add_byte(MARK_B1);
              add_byte(MARK_B2);
            end
            1: add_byte(MARK_B0);
            2: begin
              add_byte(MARK_B0);
              add_byte(MARK_B1);
            end
            default: ;
          endcase
          rows = $urandom_range(3, 1);
          for (int r = 0; r < rows; r++) begin
            fields = $urandom_range(3, 1);
            for (int f = 0; f < fields; f++) begin
              if (f > 0) add_byte(CH_COMMA);
              len = $urandom_range(4);
              if ($urandom_range(9) < 4) begin
                add_byte(CH_QUOTE);
                repeat (len) begin
                  case ($urandom_range(10))
                    6:  add_byte(CH_COMMA);
                    7:  add_byte(CH_CR);
                    8:  add_byte(CH_LF);
                    9: begin
                      add_byte(CH_CR);
                      add_byte(CH_LF);
                    end
                    10: begin
                      add_byte(CH_QUOTE);
                      add_byte(CH_QUOTE);
                    end
                    default: add_byte(plain_byte());
                  endcase
                end
                // now and then the quote stays open for the rest of the text
                if ($urandom_range(9) != 0) add_byte(CH_QUOTE);
                if ($urandom_range(9) == 0) add_byte(plain_byte());
              end else begin
                for (int k = 0; k < len; k++)
                  add_byte((k > 0 && $urandom_range(9) == 0) ? CH_QUOTE : plain_byte());
              end
            end
            if (r < rows - 1 || $urandom_range(1)) add_row_end();
            if ($urandom_range(4) == 0) add_row_end();
          end
        end
        if (text_buf.size() == 0) add_byte(plain_byte());

        // long sink hold-off while this phase keeps sending
        if ((ph == 0 || ph == 3) && !hold_taken && sent >= 24) begin
          hold_asks  <= hold_asks + 1;
          hold_taken = 1'b1;
        end

        foreach (text_buf[i])
          send_byte(text_buf[i], (i == text_buf.size() - 1), 0, 0);
        sent += text_buf.size();
      end
      settle();
    end

    // wait out any stray word before the verdict
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
